@@ design/strided_nd_scatter_address_unit_defines.svh @@
// Assertion macros shared by the checker of the strided N-d scatter address unit.
// No dependencies; each macro expects clk and rst_n in the scope where it is used.
`ifndef STRIDED_ND_SCATTER_ADDRESS_UNIT_DEFINES_SVH
`define STRIDED_ND_SCATTER_ADDRESS_UNIT_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define SNSA_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("snsa check failed");

// Next-cycle implication, checked out of reset
`define SNSA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("snsa check failed");

`endif

@@ design/snsa_pkg.sv @@
// Shared constants, types and helper functions of the strided N-d scatter address unit.
// No dependencies; the other .sv design files, snsa_chk apart, refer to it by scoped names.
`timescale 1ns / 1ps

package snsa_pkg;

    // Geometry
    localparam int MAX_DIMS   = 4;
    localparam int ADDR_WIDTH = 24;
    localparam int DIM_WIDTH  = 16;

    // Fixed field widths
    localparam int IDX_W      = 24;
    localparam int VALUE_W    = 32;
    localparam int CS_W       = 32;
    localparam int PACK_W     = 64;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    // Derived sizes
    localparam int N_CELLS    = MAX_DIMS * IDX_W;
    localparam int DIM_IDX_W  = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam int DIMN_W     = $clog2(MAX_DIMS + 1);
    localparam int DIV_W      = IDX_W + 1;

    // Register reset values
    localparam logic [2:0]        DIM_COUNT_RST = 3'd1;
    localparam logic [PACK_W-1:0] SHAPE_RST     = 64'h0001_0001_0001_0001;
    localparam logic [PACK_W-1:0] STRIDE_RST    = 64'h0001_0001_0001_0001;

    // Register indexes on the configuration channel
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FILL_VALUE = 3'd0,
        REG_DIM_COUNT  = 3'd1,
        REG_SHAPE      = 3'd2,
        REG_STRIDE     = 3'd3,
        REG_BASE       = 3'd4
    } cfg_reg_t;

    // Item moving along the cell row
    typedef struct packed {
        logic                  valid;
        logic                  last;
        logic [IDX_W-1:0]      rem;
        logic [ADDR_WIDTH-1:0] addr;
    } cell_item_t;

    // Finished write
    typedef struct packed {
        logic                  bad;
        logic                  last;
        logic [VALUE_W-1:0]    value;
        logic [ADDR_WIDTH-1:0] addr;
    } result_t;

    // Settled configuration handed to the datapath
    typedef struct packed {
        logic                                busy;
        logic                                bad;
        logic [MAX_DIMS-1:0]                 active;
        logic [VALUE_W-1:0]                  fill;
        logic [ADDR_WIDTH-1:0]               base;
        logic [MAX_DIMS-1:0][CS_W-1:0]       cs;
        logic [MAX_DIMS-1:0][DIM_WIDTH-1:0]  stride;
    } cfg_state_t;

    // Field d of a packed register; fields past the top read as zero
    function automatic logic [DIM_WIDTH-1:0] dim_field(input logic [PACK_W-1:0] packed_val,
                                                       input logic [DIM_IDX_W:0] d);
        logic [PACK_W-1:0] shifted;
        shifted = packed_val >> (d * DIM_WIDTH);
        return shifted[DIM_WIDTH-1:0];
    endfunction

    // Dimension count in use: zero counts as one, saturate at MAX_DIMS
    function automatic logic [DIMN_W-1:0] eff_dims(input logic [2:0] dim_count);
        logic [DIMN_W-1:0] n;
        if (dim_count == 3'd0)
            n = DIMN_W'(1);
        else if (32'(dim_count) > MAX_DIMS)
            n = DIMN_W'(MAX_DIMS);
        else
            n = DIMN_W'(dim_count);
        return n;
    endfunction

endpackage

@@ design/snsa_cfg.sv @@
// Configuration registers and compact-stride sequencer of the scatter address unit.
// Depends on snsa_pkg; computes suffix products of the shape after each write.
`timescale 1ns / 1ps

module snsa_cfg
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [snsa_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [snsa_pkg::CFG_DATA_W-1:0]   cfg_data,
    output snsa_pkg::cfg_state_t              cfg_state
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_START,
        ST_CALC,
        ST_CHECK
    } seq_state_t;

    logic [snsa_pkg::VALUE_W-1:0]    fill_reg;
    logic [2:0]                      dim_count_reg;
    logic [snsa_pkg::PACK_W-1:0]     shape_reg;
    logic [snsa_pkg::PACK_W-1:0]     stride_reg;
    logic [snsa_pkg::ADDR_WIDTH-1:0] base_reg;

    seq_state_t                                          state_reg;
    logic [snsa_pkg::DIM_IDX_W-1:0]                      k_reg;
    logic [snsa_pkg::DIMN_W-1:0]                         n_reg;
    logic [snsa_pkg::MAX_DIMS-1:0][snsa_pkg::CS_W-1:0]   cs_reg;
    logic                                                bad_reg;
    logic [snsa_pkg::MAX_DIMS-1:0]                       active_reg;

    logic                                                cfg_write;
    logic [snsa_pkg::DIMN_W-1:0]                         n_start;
    logic [snsa_pkg::DIM_IDX_W-1:0]                      k_start;
    logic [snsa_pkg::DIM_WIDTH-1:0]                      shape_f;
    logic [snsa_pkg::CS_W+snsa_pkg::DIM_WIDTH-1:0]       prod;
    logic                                                bad_next;
    logic [snsa_pkg::MAX_DIMS-1:0]                       active_next;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    // Hold register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            dim_count_reg <= snsa_pkg::DIM_COUNT_RST;
            shape_reg     <= snsa_pkg::SHAPE_RST;
            stride_reg    <= snsa_pkg::STRIDE_RST;
            base_reg      <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                snsa_pkg::REG_FILL_VALUE: fill_reg      <= cfg_data[snsa_pkg::VALUE_W-1:0];
                snsa_pkg::REG_DIM_COUNT:  dim_count_reg <= cfg_data[2:0];
                snsa_pkg::REG_SHAPE:      shape_reg     <= cfg_data;
                snsa_pkg::REG_STRIDE:     stride_reg    <= cfg_data;
                snsa_pkg::REG_BASE:       base_reg      <= cfg_data[snsa_pkg::ADDR_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    // Start point and one multiply step of the suffix product
    always_comb
    begin
        n_start = snsa_pkg::eff_dims(dim_count_reg);
        k_start = snsa_pkg::DIM_IDX_W'(n_start - 1'b1);
        shape_f = snsa_pkg::dim_field(shape_reg, {1'b0, k_reg});
        prod    = {{snsa_pkg::DIM_WIDTH{1'b0}}, cs_reg[k_reg]}
                * {{snsa_pkg::CS_W{1'b0}}, shape_f};
    end

    // Flag a zero stride among the dimensions in use
    always_comb
    begin
        bad_next    = 1'b0;
        active_next = '0;
        for (int d = 0; d < snsa_pkg::MAX_DIMS; d++)
        begin
            if ((snsa_pkg::DIMN_W'(d) < n_reg) && (cs_reg[d] == '0))
                bad_next = 1'b1;
        end
        for (int d = 0; d < snsa_pkg::MAX_DIMS; d++)
        begin
            active_next[d] = (snsa_pkg::DIMN_W'(d) < n_reg) && !bad_next;
        end
    end

    // Sequence the compact strides, innermost dimension first
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_START;
            k_reg      <= '0;
            n_reg      <= '0;
            cs_reg     <= '0;
            bad_reg    <= 1'b0;
            active_reg <= '0;
        end
        else if (cfg_write)
        begin
            state_reg <= ST_START;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE: ;
                ST_START:
                begin
                    n_reg           <= n_start;
                    k_reg           <= k_start;
                    cs_reg[k_start] <= snsa_pkg::CS_W'(1);
                    state_reg       <= ST_CALC;
                end
                ST_CALC:
                begin
                    if (k_reg == '0)
                    begin
                        state_reg <= ST_CHECK;
                    end
                    else
                    begin
                        cs_reg[k_reg - 1'b1] <= prod[snsa_pkg::CS_W-1:0];
                        k_reg                <= k_reg - 1'b1;
                    end
                end
                ST_CHECK:
                begin
                    bad_reg    <= bad_next;
                    active_reg <= active_next;
                    state_reg  <= ST_IDLE;
                end
                default: state_reg <= ST_START;
            endcase
        end
    end

    // Present the settled configuration
    always_comb
    begin
        cfg_state.busy   = (state_reg != ST_IDLE);
        cfg_state.bad    = bad_reg;
        cfg_state.active = active_reg;
        cfg_state.fill   = fill_reg;
        cfg_state.base   = base_reg;
        cfg_state.cs     = cs_reg;
        for (int d = 0; d < snsa_pkg::MAX_DIMS; d++)
        begin
            cfg_state.stride[d] = snsa_pkg::dim_field(stride_reg, (snsa_pkg::DIM_IDX_W + 1)'(d));
        end
    end

endmodule

@@ design/snsa_cell.sv @@
// One cell of the address row: a single restoring-division step fused with the
// stride accumulation. Depends on snsa_pkg for the item type and widths.
`timescale 1ns / 1ps

module snsa_cell
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  logic                              active,
    input  logic [snsa_pkg::DIV_W-1:0]        div,
    input  logic [snsa_pkg::ADDR_WIDTH-1:0]   stride,
    input  snsa_pkg::cell_item_t              item_in,
    output snsa_pkg::cell_item_t              item_out
);

    snsa_pkg::cell_item_t item_reg;
    snsa_pkg::cell_item_t item_next;
    logic                 take;

    // Subtract the shifted divisor and add the shifted stride when it fits
    always_comb
    begin
        take      = active && ({1'b0, item_in.rem} >= div);
        item_next = item_in;
        if (take)
        begin
            item_next.rem  = item_in.rem - div[snsa_pkg::IDX_W-1:0];
            item_next.addr = item_in.addr + stride;
        end
    end

    // Advance the item whenever the row moves
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_reg <= '0;
        end
        else if (en)
        begin
            item_reg <= item_next;
        end
    end

    assign item_out = item_reg;

endmodule

@@ design/snsa_skid.sv @@
// Output register with a one-entry skid stage for the scatter address unit.
// Depends on snsa_pkg for the result type.
`timescale 1ns / 1ps

module snsa_skid
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  snsa_pkg::result_t    in_item,
    output logic                 full,
    output logic                 out_valid,
    input  logic                 out_ready,
    output snsa_pkg::result_t    out_item
);

    logic              out_valid_reg;
    logic              skid_valid_reg;
    snsa_pkg::result_t out_reg;
    snsa_pkg::result_t skid_reg;
    logic              fire;

    assign fire = in_valid && !skid_valid_reg;

    // Load output from skid first, else from the row; park in skid on stall
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || out_ready)
        begin
            out_valid_reg  <= skid_valid_reg || fire;
            skid_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || out_ready)
        begin
            out_reg <= skid_valid_reg ? skid_reg : in_item;
        end
        else if (fire)
        begin
            skid_reg <= in_item;
        end
    end

    assign full      = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

endmodule

@@ design/strided_nd_scatter_address_unit.sv @@
// Top level of the strided N-d scatter address unit: config block, cell row, output skid.
// Depends on snsa_pkg, snsa_cfg, snsa_cell and snsa_skid.
`timescale 1ns / 1ps

// Takes one element index per cycle and gives one write
// (address, fill value, last mark, bad-shape flag) per index; a new item enters
// every cycle. The path is the row of MAX_DIMS * 24 cells, each resolving one
// coordinate bit of one dimension (shift-subtract on the remainder, shift-add of the
// view stride into the address), plus the output register. Back-pressure freezes
// the whole row once the one-entry skid behind the output register is taken.
// After reset and after every configuration write, input is held off while the
// compact strides are rebuilt, one 32x16 multiply per cycle.
module strided_nd_scatter_address_unit
(
    input  logic                             clk,
    input  logic                             rst_n,
    // Input items
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [23:0]                      s_axis_tdata,  // [23:0] element_index
    input  logic                             s_axis_tlast,  // last_element
    // Output items
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [55:0]                      m_axis_tdata,  // [23:0] write_address,
                                                            // [55:24] write_value
    output logic                             m_axis_tlast,  // last_write
    output logic                             m_axis_tuser,  // [0] bad_shape
    // Configuration writes
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [snsa_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [snsa_pkg::CFG_DATA_W-1:0]  cfg_data
);

    snsa_pkg::cfg_state_t cfg_state;
    snsa_pkg::cell_item_t chain [0:snsa_pkg::N_CELLS];
    snsa_pkg::result_t    row_result;
    snsa_pkg::result_t    out_item;
    logic                 skid_full;
    logic                 row_en;

    snsa_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg_state (cfg_state)
    );

    // Advance the row while the skid has room; take input only when settled
    assign row_en        = !skid_full;
    assign s_axis_tready = row_en && !cfg_state.busy;

    // Feed the head of the row
    always_comb
    begin
        chain[0].valid = s_axis_tvalid && !cfg_state.busy;
        chain[0].last  = s_axis_tlast;
        chain[0].rem   = s_axis_tdata[snsa_pkg::IDX_W-1:0];
        chain[0].addr  = cfg_state.base;
    end

    // Cell k handles dimension k / 24, coordinate bit 23 - k % 24
    for (genvar k = 0; k < snsa_pkg::N_CELLS; k++)
    begin : g_cell
        localparam int Dim = k / snsa_pkg::IDX_W;
        localparam int Bit = snsa_pkg::IDX_W - 1 - (k % snsa_pkg::IDX_W);

        logic [snsa_pkg::CS_W+snsa_pkg::IDX_W-1:0] div_wide;
        logic [snsa_pkg::DIV_W-1:0]                div;
        logic [snsa_pkg::ADDR_WIDTH-1:0]           stride_sh;

        // Saturate a shifted divisor that no remainder can reach
        always_comb
        begin
            div_wide = {{snsa_pkg::IDX_W{1'b0}}, cfg_state.cs[Dim]} << Bit;
            if (|div_wide[snsa_pkg::CS_W+snsa_pkg::IDX_W-1:snsa_pkg::IDX_W])
                div = '1;
            else
                div = {1'b0, div_wide[snsa_pkg::IDX_W-1:0]};
            stride_sh = snsa_pkg::ADDR_WIDTH'(cfg_state.stride[Dim]) << Bit;
        end

        snsa_cell u_cell
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (row_en),
            .active   (cfg_state.active[Dim]),
            .div      (div),
            .stride   (stride_sh),
            .item_in  (chain[k]),
            .item_out (chain[k+1])
        );
    end

    // Assemble the write at the end of the row
    always_comb
    begin
        row_result.addr  = chain[snsa_pkg::N_CELLS].addr;
        row_result.value = cfg_state.fill;
        row_result.last  = chain[snsa_pkg::N_CELLS].last;
        row_result.bad   = cfg_state.bad;
    end

    snsa_skid u_skid
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (chain[snsa_pkg::N_CELLS].valid),
        .in_item   (row_result),
        .full      (skid_full),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_item  (out_item)
    );

    assign m_axis_tdata = {out_item.value, out_item.addr};
    assign m_axis_tlast = out_item.last;
    assign m_axis_tuser = out_item.bad;

endmodule

@@ design/snsa_chk.sv @@
// Port-level checker for the strided N-d scatter address unit, bound to the top level.
// Depends on strided_nd_scatter_address_unit_defines.svh for the assertion macros.
`timescale 1ns / 1ps
`include "strided_nd_scatter_address_unit_defines.svh"

module snsa_chk
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,
    input  logic        s_axis_tlast,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [55:0] m_axis_tdata,
    input  logic        m_axis_tlast,
    input  logic        m_axis_tuser,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    logic [7:0]  pending_reg;
    logic        in_fire;
    logic        out_fire;
    logic        out_stall;
    logic [57:0] out_word;

    assign in_fire   = s_axis_tvalid && s_axis_tready;
    assign out_fire  = m_axis_tvalid && m_axis_tready;
    assign out_stall = m_axis_tvalid && !m_axis_tready;
    assign out_word  = {m_axis_tuser, m_axis_tlast, m_axis_tdata};

    // Track items accepted but not yet delivered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else if (in_fire && !out_fire)
        begin
            pending_reg <= pending_reg + 8'd1;
        end
        else if (out_fire && !in_fire)
        begin
            pending_reg <= pending_reg - 8'd1;
        end
    end

    // Every output item stems from an accepted input item
    `SNSA_ASSERT_NOW(a_no_invented, m_axis_tvalid, pending_reg != 8'd0)
    // A stalled output holds its item
    `SNSA_ASSERT_NEXT(a_out_hold, out_stall, m_axis_tvalid && $stable(out_word))
    // Strides are rebuilt after a register write before input is taken
    `SNSA_ASSERT_NEXT(a_cfg_settle, cfg_valid && cfg_ready, !s_axis_tready)
    // Strides are built after reset before input is taken
    `SNSA_ASSERT_NOW(a_reset_settle, $past(!rst_n), !s_axis_tready)

endmodule

bind strided_nd_scatter_address_unit snsa_chk u_snsa_chk (.*);

@@ tb/sv/testbench.sv @@
// Self-checking bench for strided_nd_scatter_address_unit: directed corner cases, then random fills.
// Depends on snsa_pkg and the unit's RTL; an in-bench address ledger predicts every write.
`timescale 1ns / 1ps

module testbench;

    localparam int IDLE_LIMIT    = 5000;
    localparam int DRAIN_CYCLES  = 120;
    localparam int LONG_HOLD     = 400;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS   = 200;

    // One write as the unit should emit it
    typedef struct packed {
        logic        bad;
        logic        last;
        logic [31:0] value;
        logic [23:0] addr;
    } scatter_write_t;

    // Register copy, compact strides and the queue of writes still owed by the unit
    class address_ledger;
        logic [31:0]    fill;
        logic [2:0]     dims;
        logic [63:0]    shape;
        logic [63:0]    stride;
        logic [23:0]    base;
        logic [31:0]    cs[snsa_pkg::MAX_DIMS];
        int             used_dims;
        bit             shape_bad;
        scatter_write_t owed_writes[$];
        int             elements;
        int             writes;
        int             bad_writes;
        int             reg_writes;
        int             failures;

        function new();
            fill       = '0;
            dims       = snsa_pkg::DIM_COUNT_RST;
            shape      = snsa_pkg::SHAPE_RST;
            stride     = snsa_pkg::STRIDE_RST;
            base       = '0;
            elements   = 0;
            writes     = 0;
            bad_writes = 0;
            reg_writes = 0;
            failures   = 0;
            rebuild_strides();
        endfunction

        // Suffix products of the inner sizes; dimension 0's size never enters
        function void rebuild_strides();
            if (dims == 3'd0)
                used_dims = 1;
            else if (int'(dims) > snsa_pkg::MAX_DIMS)
                used_dims = snsa_pkg::MAX_DIMS;
            else
                used_dims = int'(dims);
            cs[used_dims - 1] = 32'd1;
            for (int d = used_dims - 1; d > 0; d--)
                cs[d - 1] = cs[d]
                          * 32'(shape[d * snsa_pkg::DIM_WIDTH +: snsa_pkg::DIM_WIDTH]);
            shape_bad = 1'b0;
            for (int d = 0; d < used_dims; d++)
                if (cs[d] == 32'd0)
                    shape_bad = 1'b1;
        endfunction

        function void apply_register(snsa_pkg::cfg_reg_t idx, logic [63:0] val);
            reg_writes++;
            case (idx)
                snsa_pkg::REG_FILL_VALUE: fill   = val[31:0];
                snsa_pkg::REG_DIM_COUNT:  dims   = val[2:0];
                snsa_pkg::REG_SHAPE:      shape  = val;
                snsa_pkg::REG_STRIDE:     stride = val;
                snsa_pkg::REG_BASE:       base   = val[23:0];
                default: ;
            endcase
            rebuild_strides();
        endfunction

        // Number of elements in the view, zero when dimension 0 is empty
        function longint unsigned view_extent();
            return longint'(cs[0]) * longint'(shape[snsa_pkg::DIM_WIDTH-1:0]);
        endfunction

        // Split the index by the compact strides, accumulate coordinate times view stride
        function scatter_write_t predict_write(logic [23:0] idx, logic last);
            scatter_write_t w;
            logic [31:0]    rem;
            logic [31:0]    addr;
            logic [31:0]    coord;
            rem  = 32'(idx);
            addr = 32'(base);
            if (!shape_bad)
                for (int d = 0; d < used_dims; d++)
                begin
                    coord = rem / cs[d];
                    addr  = addr + coord
                          * 32'(stride[d * snsa_pkg::DIM_WIDTH +: snsa_pkg::DIM_WIDTH]);
                    rem   = rem % cs[d];
                end
            w.addr  = addr[23:0];
            w.value = fill;
            w.last  = last;
            w.bad   = shape_bad;
            return w;
        endfunction

        function void note_element(logic [23:0] idx, logic last);
            elements++;
            owed_writes.push_back(predict_write(idx, last));
        endfunction

        function void report_mismatch(string field, logic [31:0] want, logic [31:0] got);
            failures++;
            $display("%0t: write %0d %s expected %h actual %h",
                     $time, writes, field, want, got);
        endfunction

        function void check_write(logic [55:0] data, logic last, logic bad);
            scatter_write_t want;
            writes++;
            if (bad)
                bad_writes++;
            if (owed_writes.size() == 0)
            begin
                failures++;
                $display("%0t: write %0d expected none actual addr %h value %h",
                         $time, writes, data[23:0], data[55:24]);
                return;
            end
            want = owed_writes.pop_front();
            if (data[23:0] !== want.addr)
                report_mismatch("write_address", 32'(want.addr), 32'(data[23:0]));
            if (data[55:24] !== want.value)
                report_mismatch("write_value", want.value, data[55:24]);
            if (last !== want.last)
                report_mismatch("last_write", 32'(want.last), 32'(last));
            if (bad !== want.bad)
                report_mismatch("bad_shape", 32'(want.bad), 32'(bad));
        endfunction
    endclass

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata  = '0;
    logic        s_axis_tlast  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [55:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        m_axis_tuser;
    logic        cfg_valid     = 1'b0;
    logic        cfg_ready;
    logic [snsa_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [snsa_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

    address_ledger board = new();

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_requests = 0;
    int holds_served = 0;
    int hold_left = 0;
    int idle_cycles = 0;

    strided_nd_scatter_address_unit i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #2 clk = ~clk;

    // Receiver: serve long hold requests, otherwise stall at random
    always @(negedge clk)
    begin
        if (hold_requests != holds_served)
        begin
            holds_served  = hold_requests;
            hold_left     = LONG_HOLD;
            m_axis_tready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left     = hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Observe all three channels at the rising edge
    always @(posedge clk)
    begin
        if (cfg_valid && cfg_ready)
            board.apply_register(snsa_pkg::cfg_reg_t'(cfg_index), cfg_data);
        if (s_axis_tvalid && s_axis_tready)
            board.note_element(s_axis_tdata, s_axis_tlast);
        if (m_axis_tvalid && m_axis_tready)
            board.check_write(m_axis_tdata, m_axis_tlast, m_axis_tuser);
    end

    // Watchdog: end the run when nothing moves for too long
    initial
    begin
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((cfg_valid && cfg_ready) || (s_axis_tvalid && s_axis_tready)
                || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("%0t: no item moved for %0d cycles", $time, IDLE_LIMIT);
        $display("end of test: mismatches");
        $finish;
    end

    function automatic void set_idle_mode(int mode);
        case (mode % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 62; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 62; end
            default: begin send_idle_pct = 38; recv_stall_pct = 38; end
        endcase
    endfunction

    // Offer one element; leaves valid high, returns at the next falling edge
    task automatic offer_element(logic [23:0] idx, logic last);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= idx;
        s_axis_tlast  <= last;
        do
            @(posedge clk);
        while (!s_axis_tready);
        @(negedge clk);
    endtask

    // Drop valid and wait until every owed write has arrived
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (board.owed_writes.size() != 0);
        @(negedge clk);
    endtask

    task automatic write_register(snsa_pkg::cfg_reg_t idx, logic [63:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
    endtask

    // Reprogram all five registers with the unit idle
    task automatic apply_setting(logic [31:0] fill, logic [2:0] dims, logic [63:0] shape,
                                 logic [63:0] stride, logic [23:0] base);
        wait_drained();
        repeat (4) @(negedge clk);
        write_register(snsa_pkg::REG_FILL_VALUE, 64'(fill));
        write_register(snsa_pkg::REG_DIM_COUNT, 64'(dims));
        write_register(snsa_pkg::REG_SHAPE, shape);
        write_register(snsa_pkg::REG_STRIDE, stride);
        write_register(snsa_pkg::REG_BASE, 64'(base));
        cfg_valid <= 1'b0;
    endtask

    // Mostly small shapes so fills stay short; some wide, some with an empty inner dimension
    task automatic random_setting();
        logic [2:0]  dims;
        logic [63:0] shape;
        logic [63:0] stride;
        int          pick;
        pick = $urandom_range(0, 9);
        if (pick < 8)
            dims = 3'(1 + pick % 4);
        else if (pick == 8)
            dims = 3'd0;
        else
            dims = 3'($urandom_range(5, 7));
        pick = $urandom_range(0, 9);
        for (int d = 0; d < snsa_pkg::MAX_DIMS; d++)
            shape[d * snsa_pkg::DIM_WIDTH +: snsa_pkg::DIM_WIDTH] =
                (pick < 6) ? 16'($urandom_range(1, 8)) : 16'($urandom_range(1, 300));
        if (pick == 8)
            shape = {$urandom, $urandom};
        else if (pick == 9)
            shape[$urandom_range(1, 3) * snsa_pkg::DIM_WIDTH +: snsa_pkg::DIM_WIDTH] = '0;
        stride = {$urandom, $urandom};
        if ($urandom_range(0, 9) == 0)
            stride = 64'($urandom_range(0, 3));
        apply_setting($urandom, dims, shape, stride, 24'($urandom));
    endtask

    function automatic logic [23:0] pick_index();
        longint unsigned extent;
        extent = board.view_extent();
        if (extent == 0 || $urandom_range(0, 4) == 0)
            return 24'($urandom);
        if (extent > 64'h100_0000)
            extent = 64'h100_0000;
        return 24'($urandom_range(0, 32'(extent - 1)));
    endfunction

    // Random phase: mostly in-view fill runs ending in last, the rest loose indices
    task automatic random_phase(int phase);
        logic [23:0] start;
        int          run_len;
        int          sent;
        sent = 0;
        random_setting();
        set_idle_mode(phase);
        if (phase == 1)
            hold_requests++;
        while (sent < PHASE_ITEMS)
        begin
            if (phase == 2 && sent >= PHASE_ITEMS / 2 && sent < PHASE_ITEMS / 2 + 40)
            begin
                wait_drained();
                sent = PHASE_ITEMS / 2 + 40;
            end
            if ($urandom_range(0, 9) < 7)
            begin
                start   = pick_index();
                run_len = $urandom_range(1, 32);
                for (int i = 0; i < run_len; i++)
                    offer_element(start + 24'(i), i == run_len - 1);
                sent += run_len;
            end
            else
            begin
                offer_element(24'($urandom), 1'($urandom));
                sent++;
            end
        end
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        set_idle_mode(0);

        // Reset setting: one dimension, unit stride
        offer_element(24'h000000, 1'b0);
        offer_element(24'hFFFFFF, 1'b1);

        // Four dimensions, widest strides and base, indices at and past the view edge
        apply_setting(32'hFFFF_FFFF, 3'd4, 64'h0006_0005_0004_0003,
                      64'hFFFF_FFFF_FFFF_FFFF, 24'hFFFFFF);
        offer_element(24'd0, 1'b0);
        offer_element(24'd1, 1'b0);
        offer_element(24'd359, 1'b0);
        offer_element(24'd360, 1'b0);
        offer_element(24'hFFFFFF, 1'b1);

        // Empty inner dimension gives a zero compact stride
        apply_setting(32'h3F80_0000, 3'd3, 64'h0002_0002_0000_0005,
                      64'h1234_5678_9ABC_DEF0, 24'hABCDEF);
        offer_element(24'd7, 1'b0);
        offer_element(24'hFFFFFF, 1'b1);

        // Count above the limit saturates; suffix product wraps to zero
        apply_setting(32'h7FC0_0000, 3'd7, 64'h0004_8000_8000_0001,
                      64'h0001_0002_0003_0004, 24'h000100);
        offer_element(24'd3, 1'b1);
        offer_element(24'h800000, 1'b0);

        // Count zero acts as one; empty outer dimension does not matter
        apply_setting(32'h0000_0000, 3'd0, 64'h0000_0000_0000_0000,
                      64'h0000_0000_0000_FFFF, 24'h000000);
        offer_element(24'hFFFFFF, 1'b0);
        offer_element(24'd1, 1'b0);
        offer_element(24'h800000, 1'b1);

        // Largest shape, nonzero strides after wrap
        apply_setting(32'h5A5A_A5A5, 3'd4, 64'hFFFF_FFFF_FFFF_FFFF,
                      64'hFFFF_FFFF_FFFF_FFFF, 24'h000000);
        offer_element(24'd0, 1'b0);
        offer_element(24'hFFFE, 1'b0);
        offer_element(24'hFFFFFF, 1'b1);

        for (int p = 0; p < RANDOM_PHASES; p++)
            random_phase(p);

        // Drain and give the pipeline time to show any stray write
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d elements and %0d writes, %0d of them flagged bad shape",
                 board.elements, board.writes, board.bad_writes);
        $display("%0d register writes over %0d settings, including a long output stall",
                 board.reg_writes, RANDOM_PHASES + 5);
        if (board.failures == 0 && board.owed_writes.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

@@ strided_nd_scatter_address_unit.f @@
+incdir+design
design/snsa_pkg.sv
design/snsa_cfg.sv
design/snsa_cell.sv
design/snsa_skid.sv
design/strided_nd_scatter_address_unit.sv
design/snsa_chk.sv
tb/sv/testbench.sv
